FILE: design/rris_pkg.sv
package rris_pkg;

    localparam int TIME_W    = 32;
    localparam int DUTY_W    = 8;
    localparam int SERVING_W = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PUMP_DURATION = 3'd0;
    localparam cfg_idx_t REG_SOAK_PAUSE    = 3'd1;
    localparam cfg_idx_t REG_THRESHOLDS    = 3'd2;
    localparam cfg_idx_t REG_BED_LOCK      = 3'd3;
    localparam cfg_idx_t REG_PUMP_DUTY     = 3'd4;

    localparam logic [TIME_W-1:0] PUMP_DURATION_RESET = 32'd30000;
    localparam logic [TIME_W-1:0] SOAK_PAUSE_RESET    = 32'd600000;
    localparam logic [DUTY_W-1:0] PUMP_DUTY_RESET     = 8'd255;

    typedef struct packed {
        logic load;
        logic expire_step;
        logic scan_init;
        logic scan_step;
        logic finish_check;
        logic hard_stop;
        logic publish;
    } rris_cmd_t;

    typedef struct packed {
        logic stop;
        logic pumping;
        logic cnt_last;
        logic found;
        logic out_busy;
    } rris_status_t;

endpackage

FILE: design/rris_ctrl.sv
module rris_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rris_pkg::rris_status_t status,
    output rris_pkg::rris_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXPIRE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FINISH = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXPIRE;
                end
            end
            S_EXPIRE:
            begin
                if (status.stop)
                begin
                    cmd.hard_stop = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.expire_step = 1'b1;
                    if (status.cnt_last)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = status.pumping ? S_FINISH : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.found || status.cnt_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_FINISH:
            begin
                cmd.finish_check = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                // The result register must be free before it is overwritten.
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/rris_dp.sv
module rris_dp #(
    parameter int BED_COUNT  = 5,
    parameter int LEVEL_BITS = 7,
    parameter int THR_W      = BED_COUNT * LEVEL_BITS,
    parameter int CFG_W      = (THR_W > rris_pkg::TIME_W) ? THR_W : rris_pkg::TIME_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rris_pkg::rris_cmd_t               cmd,
    output rris_pkg::rris_status_t            status,
    input  logic                              cfg_we,
    input  rris_pkg::cfg_idx_t                cfg_index,
    input  logic [CFG_W-1:0]                  cfg_data,
    input  logic [rris_pkg::TIME_W-1:0]       now_ms,
    input  logic [THR_W-1:0]                  soil_levels,
    input  logic [BED_COUNT-1:0]              sensor_fault_mask,
    input  logic                              water_critical,
    input  logic                              estop_active,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              pump_running,
    output logic [rris_pkg::DUTY_W-1:0]       pump_drive,
    output logic [BED_COUNT-1:0]              valve_mask,
    output logic [rris_pkg::SERVING_W-1:0]    serving_bed,
    output logic                              serving_valid,
    output logic                              watering_started,
    output logic                              watering_finished,
    output logic                              forced_stop,
    output logic [BED_COUNT-1:0]              soaking_mask
);

    localparam int IDX_W = (BED_COUNT > 1) ? $clog2(BED_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_BED = IDX_W'(BED_COUNT - 1);

    // Configuration registers.
    logic [rris_pkg::TIME_W-1:0] pump_duration_reg;
    logic [rris_pkg::TIME_W-1:0] soak_pause_reg;
    logic [THR_W-1:0]            thresholds_reg;
    logic [BED_COUNT-1:0]        bed_lock_reg;
    logic [rris_pkg::DUTY_W-1:0] pump_duty_reg;

    // Latched input item.
    logic [rris_pkg::TIME_W-1:0] now_reg;
    logic [THR_W-1:0]            soil_reg;
    logic [BED_COUNT-1:0]        fault_reg;
    logic                        stop_reg;

    // Scheduler state.
    logic                        pumping_reg;
    logic [rris_pkg::TIME_W-1:0] phase_start_reg;
    logic [IDX_W-1:0]            active_reg;
    logic [IDX_W-1:0]            ptr_reg;
    logic [BED_COUNT-1:0]        soak_flags_reg;
    logic [rris_pkg::TIME_W-1:0] soak_start_reg [BED_COUNT];

    // Sequencing and per-step events.
    logic [IDX_W-1:0]            cnt_reg;
    logic [IDX_W-1:0]            bed_reg;
    logic                        started_reg;
    logic                        finished_reg;
    logic                        forced_reg;
    logic                        out_valid_reg;

    logic [LEVEL_BITS-1:0]       soil_lv [BED_COUNT];
    logic [LEVEL_BITS-1:0]       thr_lv  [BED_COUNT];
    logic [rris_pkg::TIME_W-1:0] soak_elapsed;
    logic [rris_pkg::TIME_W-1:0] pump_elapsed;
    logic                        soak_expired;
    logic                        pump_done;
    logic                        eligible;
    logic [IDX_W-1:0]            bed_next;
    logic [IDX_W-1:0]            ptr_next;

    for (genvar g = 0; g < BED_COUNT; g++)
    begin : g_unpack
        assign soil_lv[g] = soil_reg[g*LEVEL_BITS +: LEVEL_BITS];
        assign thr_lv[g]  = thresholds_reg[g*LEVEL_BITS +: LEVEL_BITS];
    end

    assign soak_elapsed = now_reg - soak_start_reg[cnt_reg];
    assign soak_expired = soak_flags_reg[cnt_reg] && (soak_elapsed >= soak_pause_reg);
    assign pump_elapsed = now_reg - phase_start_reg;
    assign pump_done    = pump_elapsed >= pump_duration_reg;
    assign eligible     = !fault_reg[bed_reg] && !soak_flags_reg[bed_reg]
                          && !bed_lock_reg[bed_reg] && (soil_lv[bed_reg] < thr_lv[bed_reg]);
    assign bed_next     = (bed_reg == LAST_BED) ? '0 : bed_reg + 1'b1;
    assign ptr_next     = (active_reg == LAST_BED) ? '0 : active_reg + 1'b1;

    assign status.stop     = stop_reg;
    assign status.pumping  = pumping_reg;
    assign status.cnt_last = (cnt_reg == LAST_BED);
    assign status.found    = eligible;
    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_duration_reg <= rris_pkg::PUMP_DURATION_RESET;
            soak_pause_reg    <= rris_pkg::SOAK_PAUSE_RESET;
            thresholds_reg    <= '0;
            bed_lock_reg      <= '0;
            pump_duty_reg     <= rris_pkg::PUMP_DUTY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rris_pkg::REG_PUMP_DURATION: pump_duration_reg <= cfg_data[rris_pkg::TIME_W-1:0];
                rris_pkg::REG_SOAK_PAUSE:    soak_pause_reg    <= cfg_data[rris_pkg::TIME_W-1:0];
                rris_pkg::REG_THRESHOLDS:    thresholds_reg    <= cfg_data[THR_W-1:0];
                rris_pkg::REG_BED_LOCK:      bed_lock_reg      <= cfg_data[BED_COUNT-1:0];
                rris_pkg::REG_PUMP_DUTY:     pump_duty_reg     <= cfg_data[rris_pkg::DUTY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input latch and soak start times carry no reset; the soak flags guard the latter.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg   <= now_ms;
            soil_reg  <= soil_levels;
            fault_reg <= sensor_fault_mask;
            stop_reg  <= water_critical | estop_active;
        end
        if (cmd.finish_check && pump_done)
        begin
            soak_start_reg[active_reg] <= now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pumping_reg     <= 1'b0;
            phase_start_reg <= '0;
            active_reg      <= '0;
            ptr_reg         <= '0;
            soak_flags_reg  <= '0;
            cnt_reg         <= '0;
            bed_reg         <= '0;
            started_reg     <= 1'b0;
            finished_reg    <= 1'b0;
            forced_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg      <= '0;
                started_reg  <= 1'b0;
                finished_reg <= 1'b0;
                forced_reg   <= 1'b0;
            end

            if (cmd.hard_stop && pumping_reg)
            begin
                pumping_reg     <= 1'b0;
                phase_start_reg <= now_reg;
                active_reg      <= '0;
                forced_reg      <= 1'b1;
            end

            // One bed per cycle is checked for an expired soak lockout.
            if (cmd.expire_step)
            begin
                if (soak_expired)
                begin
                    soak_flags_reg[cnt_reg] <= 1'b0;
                end
                if (cmd.scan_init)
                begin
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            if (cmd.scan_init)
            begin
                bed_reg <= ptr_reg;
            end

            if (cmd.scan_step)
            begin
                if (eligible)
                begin
                    pumping_reg     <= 1'b1;
                    active_reg      <= bed_reg;
                    phase_start_reg <= now_reg;
                    started_reg     <= 1'b1;
                end
                else
                begin
                    bed_reg <= bed_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            if (cmd.finish_check && pump_done)
            begin
                soak_flags_reg[active_reg] <= 1'b1;
                ptr_reg         <= ptr_next;
                active_reg      <= '0;
                pumping_reg     <= 1'b0;
                phase_start_reg <= now_reg;
                finished_reg    <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            pump_running      <= pumping_reg;
            pump_drive        <= pumping_reg ? pump_duty_reg : '0;
            valve_mask        <= pumping_reg ? (BED_COUNT'(1) << active_reg) : '0;
            serving_bed       <= pumping_reg ? rris_pkg::SERVING_W'(active_reg) : '0;
            serving_valid     <= pumping_reg;
            watering_started  <= started_reg;
            watering_finished <= finished_reg;
            forced_stop       <= forced_reg;
            soaking_mask      <= soak_flags_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pumping_reg |-> (active_reg <= LAST_BED))
        else $error("active bed index beyond bed count while pumping");

    a_valve_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(valve_mask))
        else $error("more than one valve open");

    a_start_finish_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(watering_started && watering_finished))
        else $error("watering started and finished in one step");

    a_forced_pump_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && forced_stop) |-> (!pump_running && !watering_started))
        else $error("pump still running after a forced stop");

endmodule

FILE: design/round_robin_irrigation_scheduler.sv
// Round-robin irrigation scheduler.
// Input channel (in_valid/in_ready) carries one controller update: time, packed
// soil readings, sensor fault mask and the two hard-stop flags. Output channel
// (out_valid/out_ready) returns exactly one result per update. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while
// the block is idle, as the block itself does not enforce this. Unknown indexes
// are ignored. An update is transferred in, then goes through the soak-expiry
// pass (one bed per cycle through a single 32-bit subtract and compare), then
// either the pump-duration check or the round-robin scan, which stops at the
// first eligible bed or after the last bed, and finally loads the result
// register. A hard stop skips the expiry pass and goes straight to the result.
// One update is in flight at a time.
// The result register lets the next update be transferred in while a result
// waits; if the receiver still stalls when the next result is ready, the block
// holds it internally and accepts no further update until the register frees.
// Reset clears the schedule (idle, no soaking, pointer at bed 0) and restores
// the configuration defaults; no clearing pass is needed.
module round_robin_irrigation_scheduler #(
    parameter int  BED_COUNT  = 5,
    parameter int  LEVEL_BITS = 7,
    localparam int THR_W      = BED_COUNT * LEVEL_BITS,
    localparam int CFG_W      = (THR_W > rris_pkg::TIME_W) ? THR_W : rris_pkg::TIME_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  rris_pkg::cfg_idx_t                cfg_index,
    input  logic [CFG_W-1:0]                  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rris_pkg::TIME_W-1:0]       now_ms,
    input  logic [THR_W-1:0]                  soil_levels,
    input  logic [BED_COUNT-1:0]              sensor_fault_mask,
    input  logic                              water_critical,
    input  logic                              estop_active,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              pump_running,
    output logic [rris_pkg::DUTY_W-1:0]       pump_drive,
    output logic [BED_COUNT-1:0]              valve_mask,
    output logic [rris_pkg::SERVING_W-1:0]    serving_bed,
    output logic                              serving_valid,
    output logic                              watering_started,
    output logic                              watering_finished,
    output logic                              forced_stop,
    output logic [BED_COUNT-1:0]              soaking_mask
);

    rris_pkg::rris_cmd_t    cmd;
    rris_pkg::rris_status_t status;

    rris_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rris_dp #(
        .BED_COUNT  (BED_COUNT),
        .LEVEL_BITS (LEVEL_BITS),
        .THR_W      (THR_W),
        .CFG_W      (CFG_W)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .now_ms            (now_ms),
        .soil_levels       (soil_levels),
        .sensor_fault_mask (sensor_fault_mask),
        .water_critical    (water_critical),
        .estop_active      (estop_active),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pump_running      (pump_running),
        .pump_drive        (pump_drive),
        .valve_mask        (valve_mask),
        .serving_bed       (serving_bed),
        .serving_valid     (serving_valid),
        .watering_started  (watering_started),
        .watering_finished (watering_finished),
        .forced_stop       (forced_stop),
        .soaking_mask      (soaking_mask)
    );

endmodule
